>>> design/svpwm_pkg.sv
package svpwm_pkg;

  localparam int SQ_CELLS  = 25;
  localparam int MAX_STEPS = 24;

  localparam logic [30:0] TWO_OVER_SQRT3 = 31'd1239850262;
  localparam logic [29:0] HALF_SQRT3     = 30'd929887697;
  localparam logic [29:0] CORDIC_GAIN    = 30'd652032874;
  localparam logic [16:0] CEIL_RESET     = 17'd62259;
  localparam logic [16:0] CEIL_HALF      = 17'd32768;

  localparam longint RPROD_RESET_L = (longint'(CEIL_RESET) - 64'sd32768) *
                                     longint'(TWO_OVER_SQRT3);
  localparam logic [47:0] RPROD_RESET = 48'(RPROD_RESET_L);
  localparam logic [24:0] RAD_RESET   = 25'((RPROD_RESET_L + 64'sd2097152) >>> 22);
  localparam logic [49:0] RR_RESET    = 50'(longint'(RAD_RESET) * longint'(RAD_RESET));

  typedef struct packed {
    logic [50:0]        rem;
    logic [50:0]        root;
    logic signed [25:0] d;
    logic signed [25:0] q;
    logic               lim;
    logic [25:0]        bus;
    logic signed [31:0] vd;
    logic signed [31:0] vq;
  } sq_data_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               neg;
  } cor_data_t;

  typedef struct packed {
    logic [16:0]        duty_a;
    logic [16:0]        duty_b;
    logic [16:0]        duty_c;
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic signed [31:0] lim_d;
    logic signed [31:0] lim_q;
    logic               lim;
  } res_t;

  function automatic logic signed [33:0] arc_angle(input int idx);
    logic signed [33:0] v;
    case (idx)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/svpwm_sqrt_cell.sv
module svpwm_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  svpwm_pkg::sq_data_t din,
  output svpwm_pkg::sq_data_t dout
);
  import svpwm_pkg::*;

  localparam logic [50:0] BIT_VAL = 51'd1 << (2 * (SQ_CELLS - 1 - STEP));

  logic [50:0] trial;
  sq_data_t    dout_nxt;
  sq_data_t    dout_r;

  always_comb begin
    dout_nxt = din;
    trial    = din.root + BIT_VAL;
    if (din.rem >= trial) begin
      dout_nxt.rem  = din.rem - trial;
      dout_nxt.root = (din.root >> 1) + BIT_VAL;
    end else begin
      dout_nxt.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

>>> design/svpwm_cordic_cell.sv
module svpwm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  svpwm_pkg::cor_data_t din,
  output svpwm_pkg::cor_data_t dout
);
  import svpwm_pkg::*;

  localparam logic signed [33:0] ARC = arc_angle(STEP);

  cor_data_t dout_nxt;
  cor_data_t dout_r;

  always_comb begin
    dout_nxt = din;
    if (!din.z[33]) begin
      dout_nxt.x = din.x - (din.y >>> STEP);
      dout_nxt.y = din.y + (din.x >>> STEP);
      dout_nxt.z = din.z - ARC;
    end else begin
      dout_nxt.x = din.x + (din.y >>> STEP);
      dout_nxt.y = din.y - (din.x >>> STEP);
      dout_nxt.z = din.z + ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

>>> design/svpwm_duty_generator_core.sv
// space vector pwm duty generator, min/max midpoint injection
// input channel: in_valid/in_stall with d/q volts, angle, bus volts and
//   bus reciprocal; a request is taken when in_valid is high and in_stall low
// output channel: out_valid/out_stall with three duties, alpha/beta volts,
//   limited d/q and the limit flag
// cfg_wr_en/cfg_wr_data write the duty ceiling; write only while idle
// throughput: one request per cycle, the whole datapath is a chain of
//   registered cells (25 square root cells beside CORDIC_STEPS rotation
//   cells padded to the same length)
// latency: out_valid rises 36 cycles after the request is taken
// stall: a result waiting in the output register does not block the chain,
//   a skid register takes the next one; only when the skid is full does the
//   chain freeze and in_stall go high
// reset: synchronous active low rst_n empties the chain and output, and sets
//   the ceiling to 62259; results come out in request order
module svpwm_duty_generator_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_volt_d,
  input  logic signed [31:0] in_volt_q,
  input  logic [15:0]        in_angle,
  input  logic [25:0]        in_bus_volts,
  input  logic [23:0]        in_bus_recip,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        out_duty_phase_a,
  output logic [16:0]        out_duty_phase_b,
  output logic [16:0]        out_duty_phase_c,
  output logic signed [31:0] out_volt_alpha,
  output logic signed [31:0] out_volt_beta,
  output logic signed [31:0] out_limited_d,
  output logic signed [31:0] out_limited_q,
  output logic               out_was_limited,
  input  logic               cfg_wr_en,
  input  logic [16:0]        cfg_wr_data
);
  import svpwm_pkg::*;

  localparam int PAD_LEN = SQ_CELLS - CORDIC_STEPS;
  localparam int NST     = 5 + SQ_CELLS + 6;

  logic        en;
  logic [NST-1:0] vld_r;
  logic        out_v_r, skid_v_r;

  // ceiling and radius
  logic [16:0] ceil_r;
  logic [16:0] excess;
  logic [47:0] rprod_r;
  logic [24:0] rad_r;
  logic [49:0] rr_r;
  logic [48:0] rsum;

  assign excess = (ceil_r >= CEIL_HALF) ? (ceil_r - CEIL_HALF) : 17'd0;
  assign rsum   = {1'b0, rprod_r} + 49'd2097152;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r  <= CEIL_RESET;
      rprod_r <= RPROD_RESET;
      rad_r   <= RAD_RESET;
      rr_r    <= RR_RESET;
    end else begin
      if (cfg_wr_en) begin
        ceil_r <= cfg_wr_data;
      end
      rprod_r <= {31'd0, excess} * {17'd0, TWO_OVER_SQRT3};
      rad_r   <= rsum[46:22];
      rr_r    <= rad_r * rad_r;
    end
  end

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // p1: capture
  logic signed [31:0] vd1_r, vq1_r;
  logic [15:0]        ang1_r;
  logic [25:0]        bus1_r;
  logic [23:0]        rcp1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vd1_r  <= in_volt_d;
      vq1_r  <= in_volt_q;
      ang1_r <= in_angle;
      bus1_r <= in_bus_volts;
      rcp1_r <= in_bus_recip;
    end
  end

  // p2: normalize
  logic [31:0] magd, magq;
  logic [56:0] sumd, sumq;
  logic [41:0] nmd2_r, nmq2_r;
  logic        sd2_r, sq2_r;
  logic signed [31:0] vd2_r, vq2_r;
  logic [15:0] ang2_r;
  logic [25:0] bus2_r;

  assign magd = vd1_r[31] ? 32'(-vd1_r) : 32'(vd1_r);
  assign magq = vq1_r[31] ? 32'(-vq1_r) : 32'(vq1_r);
  assign sumd = {25'd0, magd} * {33'd0, rcp1_r} + 57'd8192;
  assign sumq = {25'd0, magq} * {33'd0, rcp1_r} + 57'd8192;

  always_ff @(posedge clk) begin
    if (en) begin
      nmd2_r <= sumd[55:14];
      nmq2_r <= sumq[55:14];
      sd2_r  <= vd1_r[31];
      sq2_r  <= vq1_r[31];
      vd2_r  <= vd1_r;
      vq2_r  <= vq1_r;
      ang2_r <= ang1_r;
      bus2_r <= bus1_r;
    end
  end

  // p3: clamp to radius
  logic [41:0] rad_ext;
  logic [24:0] dm3_r, qm3_r;
  logic        ds3_r, qs3_r, big3_r;
  logic signed [31:0] vd3_r, vq3_r;
  logic [15:0] ang3_r;
  logic [25:0] bus3_r;

  assign rad_ext = {17'd0, rad_r};

  always_ff @(posedge clk) begin
    if (en) begin
      dm3_r  <= (nmd2_r > rad_ext) ? rad_r : nmd2_r[24:0];
      qm3_r  <= (nmq2_r > rad_ext) ? rad_r : nmq2_r[24:0];
      big3_r <= (nmd2_r > rad_ext) || (nmq2_r > rad_ext);
      ds3_r  <= sd2_r;
      qs3_r  <= sq2_r;
      vd3_r  <= vd2_r;
      vq3_r  <= vq2_r;
      ang3_r <= ang2_r;
      bus3_r <= bus2_r;
    end
  end

  // p4: squares
  logic [49:0] dd4_r, qq4_r;
  logic signed [25:0] d4_r, q4_r;
  logic        big4_r;
  logic signed [31:0] vd4_r, vq4_r;
  logic [15:0] ang4_r;
  logic [25:0] bus4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dd4_r  <= dm3_r * dm3_r;
      qq4_r  <= qm3_r * qm3_r;
      d4_r   <= ds3_r ? -$signed({1'b0, dm3_r}) : $signed({1'b0, dm3_r});
      q4_r   <= qs3_r ? -$signed({1'b0, qm3_r}) : $signed({1'b0, qm3_r});
      big4_r <= big3_r;
      vd4_r  <= vd3_r;
      vq4_r  <= vq3_r;
      ang4_r <= ang3_r;
      bus4_r <= bus3_r;
    end
  end

  // p5: circle test, headroom, cordic start
  logic [50:0]        sq_sum;
  sq_data_t           sq5;
  sq_data_t           sq5_r;
  cor_data_t          cor5;
  cor_data_t          cor5_r;
  logic signed [33:0] z0;

  assign sq_sum = {1'b0, dd4_r} + {1'b0, qq4_r};

  always_comb begin
    sq5.rem  = {1'b0, rr_r - dd4_r};
    sq5.root = '0;
    sq5.d    = d4_r;
    sq5.q    = q4_r;
    sq5.lim  = big4_r || (sq_sum > {1'b0, rr_r});
    sq5.bus  = bus4_r;
    sq5.vd   = vd4_r;
    sq5.vq   = vq4_r;
    z0       = 34'($signed({ang4_r, 16'd0}));
    cor5.x   = $signed({4'd0, CORDIC_GAIN});
    cor5.y   = '0;
    cor5.neg = 1'b0;
    cor5.z   = z0;
    if (z0 > 34'sd1073741824) begin
      cor5.z   = z0 - 34'sd2147483648;
      cor5.neg = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      cor5.z   = z0 + 34'sd2147483648;
      cor5.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq5_r  <= sq5;
      cor5_r <= cor5;
    end
  end

  // cell chains
  sq_data_t  sq_w  [SQ_CELLS+1];
  cor_data_t cor_w [CORDIC_STEPS+1];
  cor_data_t pad_r [PAD_LEN];

  assign sq_w[0]  = sq5_r;
  assign cor_w[0] = cor5_r;

  genvar gi;
  generate
    for (gi = 0; gi < SQ_CELLS; gi++) begin : g_sq
      svpwm_sqrt_cell #(.STEP(gi)) u_sq (
        .clk  (clk),
        .en   (en),
        .din  (sq_w[gi]),
        .dout (sq_w[gi+1])
      );
    end
    for (gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cor
      svpwm_cordic_cell #(.STEP(gi)) u_cor (
        .clk  (clk),
        .en   (en),
        .din  (cor_w[gi]),
        .dout (cor_w[gi+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      pad_r[0] <= cor_w[CORDIC_STEPS];
      for (int k = 1; k < PAD_LEN; k++) begin
        pad_r[k] <= pad_r[k-1];
      end
    end
  end

  // t1: headroom clamp of q, sign of sin/cos
  sq_data_t           sqe;
  cor_data_t          cre;
  logic signed [25:0] rt;
  logic signed [25:0] qf;
  logic signed [25:0] d_t1_r, q_t1_r;
  logic signed [33:0] c_t1_r, s_t1_r;
  logic [25:0]        bus_t1_r;
  logic signed [31:0] vd_t1_r, vq_t1_r;
  logic               lim_t1_r;

  assign sqe = sq_w[SQ_CELLS];
  assign cre = pad_r[PAD_LEN-1];
  assign rt  = $signed({1'b0, sqe.root[24:0]});

  always_comb begin
    qf = sqe.q;
    if (sqe.lim) begin
      if (sqe.q > rt) begin
        qf = rt;
      end else if (sqe.q < -rt) begin
        qf = -rt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_t1_r   <= sqe.d;
      q_t1_r   <= qf;
      c_t1_r   <= cre.neg ? -cre.x : cre.x;
      s_t1_r   <= cre.neg ? -cre.y : cre.y;
      bus_t1_r <= sqe.bus;
      vd_t1_r  <= sqe.vd;
      vq_t1_r  <= sqe.vq;
      lim_t1_r <= sqe.lim;
    end
  end

  // t2: inverse park and limited volt products
  logic signed [26:0] bus_s1;
  logic signed [59:0] dc_t2_r, qs_t2_r, ds_t2_r, qc_t2_r;
  logic signed [52:0] pd_t2_r, pq_t2_r;
  logic [25:0]        bus_t2_r;
  logic signed [31:0] vd_t2_r, vq_t2_r;
  logic               lim_t2_r;

  assign bus_s1 = $signed({1'b0, bus_t1_r});

  always_ff @(posedge clk) begin
    if (en) begin
      dc_t2_r  <= d_t1_r * c_t1_r;
      qs_t2_r  <= q_t1_r * s_t1_r;
      ds_t2_r  <= d_t1_r * s_t1_r;
      qc_t2_r  <= q_t1_r * c_t1_r;
      pd_t2_r  <= d_t1_r * bus_s1;
      pq_t2_r  <= q_t1_r * bus_s1;
      bus_t2_r <= bus_t1_r;
      vd_t2_r  <= vd_t1_r;
      vq_t2_r  <= vq_t1_r;
      lim_t2_r <= lim_t1_r;
    end
  end

  // t3: rounding
  logic signed [60:0] a_sum, b_sum;
  logic signed [53:0] od_sum, oq_sum;
  logic signed [31:0] a_t3_r, b_t3_r, od_t3_r, oq_t3_r;
  logic [25:0]        bus_t3_r;
  logic               lim_t3_r;

  assign a_sum  = (61'(dc_t2_r) - 61'(qs_t2_r) + 61'sd536870912) >>> 30;
  assign b_sum  = (61'(ds_t2_r) + 61'(qc_t2_r) + 61'sd536870912) >>> 30;
  assign od_sum = (54'(pd_t2_r) + 54'sd8388608) >>> 24;
  assign oq_sum = (54'(pq_t2_r) + 54'sd8388608) >>> 24;

  always_ff @(posedge clk) begin
    if (en) begin
      a_t3_r   <= a_sum[31:0];
      b_t3_r   <= b_sum[31:0];
      od_t3_r  <= lim_t2_r ? od_sum[31:0] : vd_t2_r;
      oq_t3_r  <= lim_t2_r ? oq_sum[31:0] : vq_t2_r;
      bus_t3_r <= bus_t2_r;
      lim_t3_r <= lim_t2_r;
    end
  end

  // t4: clarke and volt products
  logic signed [26:0] bus_s3;
  logic signed [62:0] hp_t4_r;
  logic signed [58:0] ap_t4_r, bp_t4_r;
  logic signed [31:0] a_t4_r, od_t4_r, oq_t4_r;
  logic               lim_t4_r;

  assign bus_s3 = $signed({1'b0, bus_t3_r});

  always_ff @(posedge clk) begin
    if (en) begin
      hp_t4_r  <= b_t3_r * $signed({1'b0, HALF_SQRT3});
      ap_t4_r  <= a_t3_r * bus_s3;
      bp_t4_r  <= b_t3_r * bus_s3;
      a_t4_r   <= a_t3_r;
      od_t4_r  <= od_t3_r;
      oq_t4_r  <= oq_t3_r;
      lim_t4_r <= lim_t3_r;
    end
  end

  // t5: phase voltages
  logic signed [63:0] h_sum;
  logic signed [59:0] al_sum, be_sum;
  logic signed [33:0] h5, a5;
  logic signed [33:0] p0_r, p1_r, p2_r;
  logic signed [31:0] al_t5_r, be_t5_r, od_t5_r, oq_t5_r;
  logic               lim_t5_r;

  assign h_sum  = (64'(hp_t4_r) + 64'sd536870912) >>> 30;
  assign al_sum = (60'(ap_t4_r) + 60'sd8388608) >>> 24;
  assign be_sum = (60'(bp_t4_r) + 60'sd8388608) >>> 24;
  assign h5     = 34'($signed(h_sum[31:0]));
  assign a5     = 34'(a_t4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r     <= a5 + a5;
      p1_r     <= -a5 + h5 + h5;
      p2_r     <= -a5 - h5 - h5;
      al_t5_r  <= al_sum[31:0];
      be_t5_r  <= be_sum[31:0];
      od_t5_r  <= od_t4_r;
      oq_t5_r  <= oq_t4_r;
      lim_t5_r <= lim_t4_r;
    end
  end

  // t6: midpoint injection and duties
  logic signed [33:0] pmax, pmin;
  logic signed [35:0] mid;
  logic [16:0]        da, db, dc;
  res_t               res_nxt;
  res_t               res_r;

  function automatic logic [16:0] duty_of(input logic signed [33:0] p,
                                          input logic signed [35:0] m);
    logic signed [35:0] qd;
    logic signed [35:0] v;
    qd = 36'(p) + 36'(p) - m;
    v  = ((qd + 36'sd512) >>> 10) + 36'sd32768;
    if (v < 36'sd0) begin
      return 17'd0;
    end else if (v > 36'sd65536) begin
      return 17'd65536;
    end
    return v[16:0];
  endfunction

  always_comb begin
    pmax = p0_r;
    pmin = p0_r;
    if (p1_r > pmax) pmax = p1_r;
    if (p1_r < pmin) pmin = p1_r;
    if (p2_r > pmax) pmax = p2_r;
    if (p2_r < pmin) pmin = p2_r;
    mid = 36'(pmax) + 36'(pmin);
    da  = duty_of(p0_r, mid);
    db  = duty_of(p1_r, mid);
    dc  = duty_of(p2_r, mid);
    res_nxt.duty_a = da;
    res_nxt.duty_b = db;
    res_nxt.duty_c = dc;
    res_nxt.alpha  = al_t5_r;
    res_nxt.beta   = be_t5_r;
    res_nxt.lim_d  = od_t5_r;
    res_nxt.lim_q  = oq_t5_r;
    res_nxt.lim    = lim_t5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  // output register with skid
  logic arr;
  res_t out_d_r, skid_d_r;

  assign arr = en && vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_d_r  <= skid_d_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else if (arr) begin
        out_d_r <= res_r;
        out_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b0;
      end
    end else if (arr) begin
      skid_d_r <= res_r;
      skid_v_r <= 1'b1;
    end
  end

  assign out_valid        = out_v_r;
  assign out_duty_phase_a = out_d_r.duty_a;
  assign out_duty_phase_b = out_d_r.duty_b;
  assign out_duty_phase_c = out_d_r.duty_c;
  assign out_volt_alpha   = out_d_r.alpha;
  assign out_volt_beta    = out_d_r.beta;
  assign out_limited_d    = out_d_r.lim_d;
  assign out_limited_q    = out_d_r.lim_q;
  assign out_was_limited  = out_d_r.lim;

endmodule

>>> tb/svpwm_checker.sv
`timescale 1ns / 100ps

module svpwm_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_volt_d,
  input  logic signed [31:0] in_volt_q,
  input  logic [15:0]        in_angle,
  input  logic [25:0]        in_bus_volts,
  input  logic [23:0]        in_bus_recip,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [16:0]        out_duty_phase_a,
  input  logic [16:0]        out_duty_phase_b,
  input  logic [16:0]        out_duty_phase_c,
  input  logic signed [31:0] out_volt_alpha,
  input  logic signed [31:0] out_volt_beta,
  input  logic signed [31:0] out_limited_d,
  input  logic signed [31:0] out_limited_q,
  input  logic               out_was_limited,
  input  logic               cfg_wr_en,
  input  logic [16:0]        cfg_wr_data,
  output int                 fail_count,
  output int                 pending,
  output int                 limited_seen
);
  import svpwm_pkg::*;

  localparam longint K_RADIUS = 64'sd1239850262;
  localparam longint K_HALF_SQRT3 = 64'sd929887697;
  localparam longint K_GAIN = 64'sd652032874;
  localparam longint ATAN_LUT [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic [16:0] ceiling;
  res_t duty_queue [$];

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint bus_norm(longint v, longint unsigned recip);
    longint unsigned mag;
    longint n;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    n = longint'((mag * recip + 64'd8192) >> 14);
    return (v < 0) ? -n : n;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [16:0] to_duty(longint quad);
    longint dv;
    dv = rnd_shift(quad, 10) + 32768;
    if (dv < 0) dv = 0;
    if (dv > 65536) dv = 65536;
    return dv[16:0];
  endfunction

  function automatic res_t predict_duties(logic signed [31:0] vd, logic signed [31:0] vq,
                                          logic [15:0] ang, logic [25:0] bus_v,
                                          logic [23:0] recip, logic [16:0] ceil_v);
    res_t rs;
    longint excess, rad, d, q, x, y, z, t, c, s, a, b, h, pmax, pmin, bus, od, oq;
    longint p [3];
    logic lim, neg;
    bus = longint'(bus_v);
    excess = longint'(ceil_v) - 32768;
    if (excess < 0) excess = 0;
    rad = (excess * K_RADIUS + (64'sd1 <<< 21)) >>> 22;
    d = bus_norm(longint'(vd), longint'(recip));
    q = bus_norm(longint'(vq), longint'(recip));
    lim = d > rad || d < -rad || q > rad || q < -rad || d * d + q * q > rad * rad;
    od = longint'(vd);
    oq = longint'(vq);
    if (lim) begin
      d = clip(d, rad);
      q = clip(q, longint'(root_floor(longint'(rad * rad - d * d))));
      od = rnd_shift(d * bus, 24);
      oq = rnd_shift(q * bus, 24);
    end
    z = longint'(ang) <<< 16;
    if (z >= 64'sh80000000) z = z - 64'sh100000000;
    neg = 1'b0;
    if (z > 64'sh40000000) begin
      z = z - 64'sh80000000;
      neg = 1'b1;
    end else if (z < -64'sh40000000) begin
      z = z + 64'sh80000000;
      neg = 1'b1;
    end
    x = K_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_LUT[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_LUT[i];
      end
      x = t;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
    a = rnd_shift(d * c - q * s, 30);
    b = rnd_shift(d * s + q * c, 30);
    h = rnd_shift(b * K_HALF_SQRT3, 30);
    p[0] = 2 * a;
    p[1] = -a + 2 * h;
    p[2] = -a - 2 * h;
    pmax = p[0];
    pmin = p[0];
    for (int k = 1; k < 3; k++) begin
      if (p[k] > pmax) pmax = p[k];
      if (p[k] < pmin) pmin = p[k];
    end
    rs.duty_a = to_duty(2 * p[0] - (pmax + pmin));
    rs.duty_b = to_duty(2 * p[1] - (pmax + pmin));
    rs.duty_c = to_duty(2 * p[2] - (pmax + pmin));
    rs.alpha = 32'(rnd_shift(a * bus, 24));
    rs.beta = 32'(rnd_shift(b * bus, 24));
    rs.lim_d = 32'(od);
    rs.lim_q = 32'(oq);
    rs.lim = lim;
    return rs;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch in %s: got %0d, expected %0d (t=%0t)", field, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    limited_seen = 0;
    ceiling = CEIL_RESET;
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      ceiling <= CEIL_RESET;
    end else begin
      if (cfg_wr_en) ceiling <= cfg_wr_data;
      if (in_valid && !in_stall) begin
        duty_queue.push_back(predict_duties(in_volt_d, in_volt_q, in_angle,
                                            in_bus_volts, in_bus_recip, ceiling));
      end
      if (out_valid && !out_stall) begin
        if (duty_queue.size() == 0) begin
          $display("unexpected result at t=%0t", $time);
          fail_count++;
        end else begin
          want = duty_queue.pop_front();
          if (out_duty_phase_a !== want.duty_a) report("duty_a", out_duty_phase_a, want.duty_a);
          if (out_duty_phase_b !== want.duty_b) report("duty_b", out_duty_phase_b, want.duty_b);
          if (out_duty_phase_c !== want.duty_c) report("duty_c", out_duty_phase_c, want.duty_c);
          if (out_volt_alpha !== want.alpha) report("alpha", out_volt_alpha, want.alpha);
          if (out_volt_beta !== want.beta) report("beta", out_volt_beta, want.beta);
          if (out_limited_d !== want.lim_d) report("limited_d", out_limited_d, want.lim_d);
          if (out_limited_q !== want.lim_q) report("limited_q", out_limited_q, want.lim_q);
          if (out_was_limited !== want.lim) report("was_limited", out_was_limited, want.lim);
          if (want.lim) limited_seen++;
        end
      end
    end
    #0 pending = duty_queue.size();
  end

endmodule

>>> tb/tb_svpwm_duty_generator_core.sv
`timescale 1ns / 100ps

module tb_svpwm_duty_generator_core;
  import svpwm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PER_PHASE = 82;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_volt_d = '0;
  logic signed [31:0] in_volt_q = '0;
  logic [15:0] in_angle = '0;
  logic [25:0] in_bus_volts = '0;
  logic [23:0] in_bus_recip = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] out_duty_phase_a, out_duty_phase_b, out_duty_phase_c;
  logic signed [31:0] out_volt_alpha, out_volt_beta, out_limited_d, out_limited_q;
  logic out_was_limited;
  logic cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;

  int fail_count, pending, limited_seen;
  int cycles = 0;
  int requests_sent = 0;
  int ceilings_used = 1;
  bit steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  svpwm_duty_generator_core uut (.*);

  svpwm_checker chk (.*);

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    int hold;
    if (hold > 0) begin
      hold--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      hold = gap_len();
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      hold = gap_len();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_request(logic signed [31:0] vd, logic signed [31:0] vq,
                              logic [15:0] ang, logic [25:0] bus_v, logic [23:0] recip);
    int gap;
    @(negedge clk);
    in_volt_d <= vd;
    in_volt_q <= vq;
    in_angle <= ang;
    in_bus_volts <= bus_v;
    in_bus_recip <= recip;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_ceiling(logic [16:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ceilings_used++;
  endtask

  task automatic random_request();
    logic [25:0] bus_v;
    logic [23:0] recip;
    longint span;
    if ($urandom_range(0, 9) < 7) begin
      bus_v = 26'($urandom_range(1, 900)) * 26'd65536 + 26'($urandom_range(0, 65535));
      recip = 24'((64'd1 << 38) / longint'(bus_v));
      span = longint'(bus_v) * $urandom_range(1, 14) / 10;
      send_request(32'(longint'($urandom_range(0, 32'(2 * span))) - span),
                   32'(longint'($urandom_range(0, 32'(2 * span))) - span),
                   16'($urandom), bus_v, recip);
    end else begin
      recip = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom);
      send_request(32'($urandom), 32'($urandom), 16'($urandom), 26'($urandom), recip);
    end
  endtask

  initial begin
    logic [16:0] ceil_list [7];
    ceil_list = '{17'd32768, 17'd32767, 17'd65536, 17'd131071, 17'd0,
                  17'd50000, 17'd62259};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners at the reset ceiling
    send_request(32'sd0, 32'sd0, 16'd0, 26'd1572864, 24'd174763);
    send_request(32'h7fffffff, 32'h80000000, 16'd16384, 26'h3ffffff, 24'hffffff);
    send_request(32'h80000000, 32'h7fffffff, 16'd32768, 26'h3ffffff, 24'hffffff);
    send_request(32'h7fffffff, 32'h7fffffff, 16'd65535, 26'd0, 24'd0);
    send_request(32'd786432, 32'd0, 16'd49152, 26'd1572864, 24'd174763);
    send_request(32'd0, -32'sd786432, 16'd8192, 26'd1572864, 24'd174763);
    send_request(32'd300000, 32'd300000, 16'd24576, 26'd1572864, 24'd174763);
    send_request(-32'sd700000, 32'd700000, 16'd40960, 26'd1572864, 24'd174763);
    send_request(32'd2000000, 32'd100, 16'd57344, 26'd1572864, 24'd174763);
    send_request(32'd100, -32'sd2000000, 16'd32767, 26'd1572864, 24'd174763);
    send_request(32'd5, -32'sd5, 16'd1, 26'd65536, 24'd4194304);
    send_request(-32'sd1, 32'sd1, 16'd16383, 26'd0, 24'hffffff);

    for (int ph = 0; ph <= 7; ph++) begin
      if (ph > 0) write_ceiling(ph == 7 ? 17'($urandom_range(32768, 65536))
                                        : ceil_list[ph - 1]);
      if (ph > 0) begin
        send_request(32'd786432, 32'd786432, 16'd0, 26'd1572864, 24'd174763);
        send_request(32'h80000000, 32'h7fffffff, 16'd32768, 26'h3ffffff, 24'hffffff);
      end
      steady = (ph % 3 == 2);
      for (int n = 0; n < PER_PHASE; n++) begin
        if (n == PER_PHASE / 2) steady = !steady;
        random_request();
      end
      steady = 1'b0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("%0d requests over %0d duty ceilings, %0d of them hit the voltage limit",
             requests_sent, ceilings_used, limited_seen);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
design/svpwm_pkg.sv
design/svpwm_sqrt_cell.sv
design/svpwm_cordic_cell.sv
design/svpwm_duty_generator_core.sv
tb/svpwm_checker.sv
tb/tb_svpwm_duty_generator_core.sv
